// ----- hw/rtl/gesture_ratchet_key_mapper_assert.svh -----
// assertion macros for the gesture ratchet key mapper
`ifndef GESTURE_RATCHET_KEY_MAPPER_ASSERT_SVH
`define GESTURE_RATCHET_KEY_MAPPER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define GRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GRT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/grt_pkg.sv -----
// shared types, constants and codes of the gesture ratchet key mapper
`default_nettype none
package grt_pkg;

	localparam int BURST_LIMIT_DEF = 8;
	localparam int ACC_BITS_DEF = 32;

	localparam int SQRT_STEPS = 40;
	localparam int DIV_STEPS = 32;

	localparam logic [12:0] STEP_MIN = 13'd1;
	localparam logic [12:0] STEP_MAX = 13'd4096;
	localparam logic [12:0] STEP_RESET = 13'd64;

	// tangents in q16
	localparam logic [31:0] TAN22_Q16 = 32'd26478;
	localparam logic [31:0] TAN23_Q16 = 32'd27818;
	localparam logic [31:0] TAN67_Q16 = 32'd154393;
	localparam logic [31:0] TAN68_Q16 = 32'd162207;

	// 8-way direction codes
	localparam logic [2:0] DIR_E = 3'd0;
	localparam logic [2:0] DIR_SE = 3'd1;
	localparam logic [2:0] DIR_S = 3'd2;
	localparam logic [2:0] DIR_SW = 3'd3;
	localparam logic [2:0] DIR_W = 3'd4;
	localparam logic [2:0] DIR_NW = 3'd5;
	localparam logic [2:0] DIR_N = 3'd6;
	localparam logic [2:0] DIR_NE = 3'd7;

	localparam logic [1:0] CFG_KEYS_ESW = 2'd0;
	localparam logic [1:0] CFG_KEYS_WNE = 2'd1;
	localparam logic [1:0] CFG_STEP = 2'd2;

	typedef enum logic [1:0] {
		FUNC_MOVE = 2'd0,
		FUNC_BEGIN = 2'd1,
		FUNC_END = 2'd2,
		FUNC_TOGGLE = 2'd3
	} func_t;

	typedef struct packed {
		func_t func;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic signed [7:0] delta_h;
		logic signed [7:0] delta_v;
		logic [7:0] buttons_in;
		logic [7:0] table_id;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [15:0] keycode;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [7:0] out_h;
		logic signed [7:0] out_v;
		logic [7:0] buttons_out;
		logic gesture_on;
		logic last;
	} res_t;

	typedef enum logic [2:0] {
		MUL_AXAX,
		MUL_AYAY,
		MUL_TANA,
		MUL_TANB,
		MUL_CS
	} mul_sel_t;

	typedef enum logic [1:0] {
		EMIT_STATUS,
		EMIT_PASS,
		EMIT_TAP,
		EMIT_FINAL
	} emit_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_STATUS,
		ST_PASS,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_TEST,
		ST_DIR,
		ST_TAP,
		ST_SQRT,
		ST_CHK,
		ST_MUL,
		ST_DLOAD,
		ST_DIV,
		ST_DEND,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load_item;
		logic decode;
		mul_sel_t mul_sel;
		logic cap_sq;
		logic add_sq;
		logic cap_prod;
		logic pick_dir;
		logic sqrt_init;
		logic sqrt_step;
		logic zero_travel;
		logic comp;
		logic div_init;
		logic div_step;
		logic div_end;
		logic emit;
		emit_t emit_kind;
	} cmd_t;

	typedef struct packed {
		logic is_cmd;
		logic active;
		logic ge_step;
		logic key_nz;
		logic d_le_s;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/grt_ctrl.sv -----
// controller state machine: sequences decode, ratchet loop and result emission
`default_nettype none
module grt_ctrl #(
	parameter int BURST_LIMIT = grt_pkg::BURST_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input grt_pkg::stat_t st,
	output grt_pkg::cmd_t cmd
);
	localparam int FW = $clog2(BURST_LIMIT + 1);

	grt_pkg::state_t state_q, state_nx;
	logic [FW-1:0] fires_q;
	logic [5:0] iter_q;
	logic comp_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			grt_pkg::ST_IDLE: if (item_valid) state_nx = grt_pkg::ST_DECODE;
			grt_pkg::ST_DECODE: begin
				if (st.is_cmd) state_nx = grt_pkg::ST_STATUS;
				else if (!st.active) state_nx = grt_pkg::ST_PASS;
				else state_nx = grt_pkg::ST_SQX;
			end
			grt_pkg::ST_STATUS, grt_pkg::ST_PASS, grt_pkg::ST_FINAL: begin
				if (st.out_free) state_nx = grt_pkg::ST_IDLE;
			end
			grt_pkg::ST_SQX: state_nx = grt_pkg::ST_SQY;
			grt_pkg::ST_SQY: state_nx = grt_pkg::ST_SUM;
			grt_pkg::ST_SUM: state_nx = grt_pkg::ST_TEST;
			grt_pkg::ST_TEST: state_nx = st.ge_step ? grt_pkg::ST_DIR : grt_pkg::ST_FINAL;
			grt_pkg::ST_DIR: state_nx = grt_pkg::ST_TAP;
			grt_pkg::ST_TAP: if (!st.key_nz || st.out_free) state_nx = grt_pkg::ST_SQRT;
			grt_pkg::ST_SQRT: if (iter_q == 6'd1) state_nx = grt_pkg::ST_CHK;
			grt_pkg::ST_CHK: state_nx = st.d_le_s ? grt_pkg::ST_FINAL : grt_pkg::ST_MUL;
			grt_pkg::ST_MUL: state_nx = grt_pkg::ST_DLOAD;
			grt_pkg::ST_DLOAD: state_nx = grt_pkg::ST_DIV;
			grt_pkg::ST_DIV: if (iter_q == 6'd1) state_nx = grt_pkg::ST_DEND;
			grt_pkg::ST_DEND: begin
				if (!comp_q) state_nx = grt_pkg::ST_MUL;
				else if (fires_q == FW'(BURST_LIMIT)) state_nx = grt_pkg::ST_FINAL;
				else state_nx = grt_pkg::ST_SQX;
			end
			default: state_nx = grt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = grt_pkg::MUL_AXAX;
		cmd.emit_kind = grt_pkg::EMIT_STATUS;
		cmd.comp = comp_q;
		item_ready = 1'b0;
		unique case (state_q)
			grt_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load_item = item_valid;
			end
			grt_pkg::ST_DECODE: cmd.decode = 1'b1;
			grt_pkg::ST_STATUS: begin
				cmd.emit = st.out_free;
				cmd.emit_kind = grt_pkg::EMIT_STATUS;
			end
			grt_pkg::ST_PASS: begin
				cmd.emit = st.out_free;
				cmd.emit_kind = grt_pkg::EMIT_PASS;
			end
			grt_pkg::ST_FINAL: begin
				cmd.emit = st.out_free;
				cmd.emit_kind = grt_pkg::EMIT_FINAL;
			end
			grt_pkg::ST_SQX: cmd.mul_sel = grt_pkg::MUL_AXAX;
			grt_pkg::ST_SQY: begin
				cmd.mul_sel = grt_pkg::MUL_AYAY;
				cmd.cap_sq = 1'b1;
			end
			grt_pkg::ST_SUM: begin
				cmd.mul_sel = grt_pkg::MUL_TANA;
				cmd.add_sq = 1'b1;
			end
			grt_pkg::ST_TEST: begin
				cmd.mul_sel = grt_pkg::MUL_TANB;
				cmd.cap_prod = 1'b1;
			end
			grt_pkg::ST_DIR: cmd.pick_dir = 1'b1;
			grt_pkg::ST_TAP: begin
				cmd.sqrt_init = 1'b1;
				cmd.emit = st.key_nz && st.out_free;
				cmd.emit_kind = grt_pkg::EMIT_TAP;
			end
			grt_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
			grt_pkg::ST_CHK: cmd.zero_travel = st.d_le_s;
			grt_pkg::ST_MUL: cmd.mul_sel = grt_pkg::MUL_CS;
			grt_pkg::ST_DLOAD: cmd.div_init = 1'b1;
			grt_pkg::ST_DIV: cmd.div_step = 1'b1;
			grt_pkg::ST_DEND: cmd.div_end = 1'b1;
			default: cmd.load_item = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grt_pkg::ST_IDLE;
			fires_q <= '0;
			iter_q <= '0;
			comp_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				grt_pkg::ST_DECODE: begin
					fires_q <= '0;
					comp_q <= 1'b0;
				end
				grt_pkg::ST_DIR: fires_q <= fires_q + FW'(1);
				grt_pkg::ST_TAP: iter_q <= 6'(grt_pkg::SQRT_STEPS);
				grt_pkg::ST_DLOAD: iter_q <= 6'(grt_pkg::DIV_STEPS);
				grt_pkg::ST_SQRT, grt_pkg::ST_DIV: iter_q <= iter_q - 6'd1;
				grt_pkg::ST_CHK: comp_q <= 1'b0;
				grt_pkg::ST_DEND: comp_q <= ~comp_q;
				default: iter_q <= iter_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/grt_datapath.sv -----
// datapath: config, travel state, shared multiplier, sqrt and divide units, result register
`default_nettype none
module grt_datapath #(
	parameter int ACC_BITS = grt_pkg::ACC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input grt_pkg::item_t item,
	input wire logic cfg_valid,
	input wire logic [1:0] cfg_index,
	input wire logic [63:0] cfg_data,
	input grt_pkg::cmd_t cmd,
	output grt_pkg::stat_t st,
	input wire logic res_ready,
	output logic res_valid,
	output grt_pkg::res_t res
);
	localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	function automatic logic [15:0] key_of(input logic [63:0] lo, input logic [63:0] hi,
		input logic [2:0] d);
		logic [63:0] r;
		r = d[2] ? hi : lo;
		return r[16*d[1:0] +: 16];
	endfunction

	logic [63:0] ksw_q, kwn_q;
	logic [12:0] step_q, step_wr;
	logic [25:0] step_sq_q;
	logic active_q;
	logic [7:0] set_id_q;
	logic signed [ACC_BITS-1:0] tx_q, ty_q;
	grt_pkg::item_t item_q;
	logic [63:0] mul_q, prod_a_q, sum_q;
	logic [15:0] key_q;
	logic [79:0] rad_q;
	logic [41:0] srem_q;
	logic [39:0] root_q, drem_q;
	logic [31:0] dq_q;
	grt_pkg::res_t res_q, res_d;
	logic res_valid_q;

	logic signed [ACC_BITS:0] tx_w, ty_w, sx, sy;
	logic [ACC_BITS:0] ax_w, ay_w;
	logic [31:0] ax, ay, acomp, mul_a, mul_b;
	logic x_neg, y_neg, x_pos;
	logic [ACC_BITS-1:0] nx_sat, ny_sat;
	grt_pkg::func_t func_eff;
	logic [63:0] ay_sh;
	logic [2:0] dir, dir_fb;
	logic [15:0] key_a, key_pick;
	logic [43:0] s_rem, s_trial;
	logic [40:0] d_rem;
	logic [31:0] ceil_q, m_val;
	logic signed [ACC_BITS:0] m_w, new_w;

	// clamp of the step register on write
	always_comb begin
		step_wr = cfg_data[12:0];
		if (step_wr < grt_pkg::STEP_MIN) step_wr = grt_pkg::STEP_MIN;
		else if (step_wr > grt_pkg::STEP_MAX) step_wr = grt_pkg::STEP_MAX;
	end

	// magnitudes and signs of the travel vector
	assign tx_w = (ACC_BITS+1)'(tx_q);
	assign ty_w = (ACC_BITS+1)'(ty_q);
	assign x_neg = tx_q[ACC_BITS-1];
	assign y_neg = ty_q[ACC_BITS-1];
	assign x_pos = !x_neg && (tx_q != '0);
	assign ax_w = x_neg ? -tx_w : tx_w;
	assign ay_w = y_neg ? -ty_w : ty_w;
	assign ax = 32'(ax_w);
	assign ay = 32'(ay_w);
	assign acomp = cmd.comp ? ay : ax;

	// saturating accumulate
	assign sx = tx_w + (ACC_BITS+1)'(item_q.delta_x);
	assign sy = ty_w + (ACC_BITS+1)'(item_q.delta_y);
	assign nx_sat = (sx[ACC_BITS] != sx[ACC_BITS-1]) ? (sx[ACC_BITS] ? ACC_MIN : ACC_MAX)
		: sx[ACC_BITS-1:0];
	assign ny_sat = (sy[ACC_BITS] != sy[ACC_BITS-1]) ? (sy[ACC_BITS] ? ACC_MIN : ACC_MAX)
		: sy[ACC_BITS-1:0];

	// toggle resolves to end when the same set is active
	always_comb begin
		unique case (item_q.func)
			grt_pkg::FUNC_MOVE: func_eff = grt_pkg::FUNC_MOVE;
			grt_pkg::FUNC_BEGIN: func_eff = grt_pkg::FUNC_BEGIN;
			grt_pkg::FUNC_END: func_eff = grt_pkg::FUNC_END;
			grt_pkg::FUNC_TOGGLE: func_eff = (active_q && set_id_q == item_q.table_id)
				? grt_pkg::FUNC_END : grt_pkg::FUNC_BEGIN;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mul_a = ax;
		mul_b = ax;
		unique case (cmd.mul_sel)
			grt_pkg::MUL_AXAX: begin
				mul_a = ax;
				mul_b = ax;
			end
			grt_pkg::MUL_AYAY: begin
				mul_a = ay;
				mul_b = ay;
			end
			grt_pkg::MUL_TANA: begin
				mul_a = ax;
				mul_b = x_pos ? grt_pkg::TAN23_Q16 : grt_pkg::TAN22_Q16;
			end
			grt_pkg::MUL_TANB: begin
				mul_a = ax;
				mul_b = x_pos ? grt_pkg::TAN68_Q16 : grt_pkg::TAN67_Q16;
			end
			grt_pkg::MUL_CS: begin
				mul_a = acomp;
				mul_b = 32'({step_q, 8'h00});
			end
			default: mul_a = ax;
		endcase
	end

	// sector pick: prod_a_q holds the near edge, mul_q the far edge
	assign ay_sh = {16'h0000, ay, 16'h0000};
	always_comb begin
		if (x_pos) begin
			if (ay_sh < prod_a_q) dir = grt_pkg::DIR_E;
			else if (ay_sh < mul_q) dir = y_neg ? grt_pkg::DIR_NE : grt_pkg::DIR_SE;
			else dir = y_neg ? grt_pkg::DIR_N : grt_pkg::DIR_S;
		end else if (!x_neg) begin
			dir = y_neg ? grt_pkg::DIR_N : grt_pkg::DIR_S;
		end else begin
			if (ay_sh <= prod_a_q) dir = grt_pkg::DIR_W;
			else if (ay_sh <= mul_q) dir = y_neg ? grt_pkg::DIR_NW : grt_pkg::DIR_SW;
			else dir = y_neg ? grt_pkg::DIR_N : grt_pkg::DIR_S;
		end
		if (ax >= ay) dir_fb = x_neg ? grt_pkg::DIR_W : grt_pkg::DIR_E;
		else dir_fb = y_neg ? grt_pkg::DIR_N : grt_pkg::DIR_S;
		key_a = key_of(ksw_q, kwn_q, dir);
		// empty diagonal falls back to the dominant cardinal
		key_pick = (key_a == 16'h0000 && dir[0]) ? key_of(ksw_q, kwn_q, dir_fb) : key_a;
	end

	// one root bit per step
	assign s_rem = {srem_q, rad_q[79:78]};
	assign s_trial = {2'b00, root_q, 2'b01};
	// one quotient bit per step
	assign d_rem = {drem_q, dq_q[31]};
	// shrink by ceil(a*s/d)
	assign ceil_q = dq_q + 32'(drem_q != '0);
	assign m_val = acomp - ceil_q;
	assign m_w = (ACC_BITS+1)'(m_val);
	assign new_w = (cmd.comp ? y_neg : x_neg) ? -m_w : m_w;

	// next result word
	always_comb begin
		res_d = '0;
		res_d.gesture_on = active_q;
		unique case (cmd.emit_kind)
			grt_pkg::EMIT_STATUS: res_d.last = 1'b1;
			grt_pkg::EMIT_PASS: begin
				res_d.out_x = item_q.delta_x;
				res_d.out_y = item_q.delta_y;
				res_d.out_h = item_q.delta_h;
				res_d.out_v = item_q.delta_v;
				res_d.buttons_out = item_q.buttons_in;
				res_d.last = 1'b1;
			end
			grt_pkg::EMIT_TAP: begin
				res_d.kind = 1'b1;
				res_d.keycode = key_q;
			end
			grt_pkg::EMIT_FINAL: begin
				res_d.buttons_out = item_q.buttons_in;
				res_d.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksw_q <= '0;
			kwn_q <= '0;
			step_q <= grt_pkg::STEP_RESET;
			step_sq_q <= 26'(grt_pkg::STEP_RESET) * 26'(grt_pkg::STEP_RESET);
			active_q <= 1'b0;
			set_id_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					grt_pkg::CFG_KEYS_ESW: ksw_q <= cfg_data;
					grt_pkg::CFG_KEYS_WNE: kwn_q <= cfg_data;
					grt_pkg::CFG_STEP: begin
						step_q <= step_wr;
						step_sq_q <= 26'(step_wr) * 26'(step_wr);
					end
					default: step_q <= step_q;
				endcase
			end
			if (cmd.decode) begin
				if (func_eff == grt_pkg::FUNC_BEGIN) begin
					active_q <= 1'b1;
					set_id_q <= item_q.table_id;
					tx_q <= '0;
					ty_q <= '0;
				end else if (func_eff == grt_pkg::FUNC_END) begin
					active_q <= 1'b0;
					tx_q <= '0;
					ty_q <= '0;
				end else if (active_q) begin
					tx_q <= nx_sat;
					ty_q <= ny_sat;
				end
			end
			if (cmd.zero_travel) begin
				tx_q <= '0;
				ty_q <= '0;
			end
			if (cmd.div_end) begin
				if (cmd.comp) ty_q <= ACC_BITS'(new_w);
				else tx_q <= ACC_BITS'(new_w);
			end
			if (cmd.emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= item;
		mul_q <= 64'(mul_a) * 64'(mul_b);
		if (cmd.cap_sq) sum_q <= mul_q;
		if (cmd.add_sq) sum_q <= sum_q + mul_q;
		if (cmd.cap_prod) prod_a_q <= mul_q;
		if (cmd.pick_dir) key_q <= key_pick;
		if (cmd.sqrt_init) begin
			rad_q <= {sum_q, 16'h0000};
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[77:0], 2'b00};
			if (s_rem >= s_trial) begin
				srem_q <= 42'(s_rem - s_trial);
				root_q <= {root_q[38:0], 1'b1};
			end else begin
				srem_q <= 42'(s_rem);
				root_q <= {root_q[38:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			drem_q <= 40'(mul_q[52:32]);
			dq_q <= mul_q[31:0];
		end
		if (cmd.div_step) begin
			if (d_rem >= {1'b0, root_q}) begin
				drem_q <= 40'(d_rem - {1'b0, root_q});
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				drem_q <= 40'(d_rem);
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
		if (cmd.emit) res_q <= res_d;
	end

	always_comb begin
		st = '0;
		st.is_cmd = (func_eff != grt_pkg::FUNC_MOVE);
		st.active = active_q;
		st.ge_step = (sum_q >= 64'(step_sq_q));
		st.key_nz = (key_q != 16'h0000);
		st.d_le_s = (root_q <= 40'({step_q, 8'h00}));
		st.out_free = !res_valid_q || res_ready;
	end
	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
`default_nettype wire

// ----- hw/rtl/gesture_ratchet_key_mapper.sv -----
// top level of the gesture ratchet key mapper: controller plus datapath
// usage:
//  - item channel (item_valid/item_ready/item) takes one pointer report or command word
//  - res channel (res_valid/res_ready/res) gives result words, last set on the final one
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes key tables and step;
//    cfg_ready is always high, write only while the block is idle
//  - commands and moves while idle: one result word
//  - moves while a gesture is on: each tap runs a root extraction and up to two divides
//    through one shared divide unit, with at most BURST_LIMIT taps in a burst
//  - one word in work at a time; item_ready rises once the last result word is loaded
//    in the output register, so the next word is taken while that result waits
//  - a stalled receiver holds the result register and the controller waits for it
//  - reset clears gesture state, travel vector and key tables, step returns to 64,
//    and no result is pending
`default_nettype none
module gesture_ratchet_key_mapper #(
	parameter int BURST_LIMIT = grt_pkg::BURST_LIMIT_DEF,
	parameter int ACC_BITS = grt_pkg::ACC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input grt_pkg::item_t item,
	output logic res_valid,
	input wire logic res_ready,
	output grt_pkg::res_t res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [63:0] cfg_data
);
	`include "gesture_ratchet_key_mapper_assert.svh"

	grt_pkg::cmd_t cmd;
	grt_pkg::stat_t st;

	// config registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencer
	grt_ctrl #(
		.BURST_LIMIT(BURST_LIMIT)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.st(st),
		.cmd(cmd)
	);

	// arithmetic, state and result register
	grt_datapath #(
		.ACC_BITS(ACC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.st(st),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res(res)
	);

	// one word in work at a time
	`GRT_ASSERT_NXT(a_busy_after_take, item_valid && item_ready, !item_ready, "took word while busy")
	// key taps are never final and only while a gesture is on
	`GRT_ASSERT_IMP(a_tap_form, res_valid && res.kind, !res.last && res.gesture_on, "bad tap word")
	// every non-tap word closes its item
	`GRT_ASSERT_IMP(a_report_last, res_valid && !res.kind, res.last, "report word not last")
	// result only loaded when the output register is free
	`GRT_ASSERT_IMP(a_emit_free, cmd.emit, st.out_free, "result overwritten")

endmodule
`default_nettype wire
